>>> rtl/assert_macros.svh
// assertion macros used by the back end rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define NLTF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while in reset
`define NLTF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/nltf_pkg.sv
// shared types, codes and helpers of the neighbor link table forwarder
package nltf_pkg;

   // operation codes
   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_FWD  = 2'd1;
   localparam logic [1:0] OP_FIND = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NODES_FULL = 3'd1;
   localparam logic [2:0] ST_LINKS_FULL = 3'd2;
   localparam logic [2:0] ST_BAD_PORT   = 3'd3;
   localparam logic [2:0] ST_UNKNOWN    = 3'd4;
   localparam logic [2:0] ST_NO_LINKS   = 3'd5;

   localparam logic [7:0] BCAST_BYTE = 8'hFF;

   // command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QAW    = 1;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] id_u;
      logic [31:0] id_v;
      logic [3:0]  source_node;
      logic [7:0]  port_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  dest_node;
      logic [31:0] dest_id;
      logic [3:0]  out_port;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] id_u;
      logic [31:0] id_v;
      logic [3:0]  source_node;
      logic [7:0]  port_byte;
      logic        bcast;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } head_type;

   function automatic rsp_type pack_rsp(input logic [2:0]  status,
                                        input logic [3:0]  dest_node,
                                        input logic [31:0] dest_id,
                                        input logic [3:0]  out_port,
                                        input logic        last);
      rsp_type r;
      r.status    = status;
      r.dest_node = dest_node;
      r.dest_id   = dest_id;
      r.out_port  = out_port;
      r.last      = last;
      return r;
   endfunction

endpackage

>>> rtl/neighbor_link_table_forwarder_top.sv
// top level of the neighbor link table forwarder
//
// command-style block: a transaction is taken when start is high and busy is
// low; each result shows on rsp_payload for exactly one cycle with rsp_strobe
// high and cannot be held off, so the receiver must take it in that cycle.
// the front end queues up to two commands, so start may be accepted while the
// back end is still working; busy rises only when that queue is full. the
// back end works one command at a time with one read port on each memory:
// find and add link both scan the node id memory one entry per cycle; a
// forward reads the source node's link count and then walks its links, one
// for a single forward and all n for a broadcast over n links, and the
// results come out one per cycle with last on the final one.
// error results (table full, link list full, bad port, unknown node, no
// neighbors) are single results with last set. op code 3 is accepted and
// gives no result. all memories start undefined and need no clearing pass:
// only entries below the node count and below each node's link count are read.
module neighbor_link_table_forwarder_top #(
   parameter int MAX_NODES = 16,
   parameter int MAX_LINKS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nltf_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output nltf_pkg::rsp_type rsp_payload
);
   import nltf_pkg::*;

   // command queue head and pop handshake between the two halves
   head_type head;
   logic     pop;

   // front end: transaction accept, op classification, command queue
   nltf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .head        (head),
      .pop         (pop)
   );

   // back end: id scan, capacity checks, table updates, link walk
   nltf_back #(
      .MAX_NODES (MAX_NODES),
      .MAX_LINKS (MAX_LINKS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/nltf_ram.sv
// generic single write port ram with registered read
module nltf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/nltf_front.sv
// front end: takes transactions, classifies them and queues commands
module nltf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nltf_pkg::req_type req_payload,
   output nltf_pkg::head_type head,
   input  logic              pop
);
   import nltf_pkg::*;

   cmd_type          q_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]     count_ff, count_in;
   logic             push;
   cmd_type          cmd;

   assign busy = (count_ff == (QAW+1)'(QDEPTH));

   // unused op code is accepted and dropped here
   assign push = start && !busy && (req_payload.op inside {OP_ADD, OP_FWD, OP_FIND});

   always_comb begin
      cmd.op          = req_payload.op;
      cmd.id_u        = req_payload.id_u;
      cmd.id_v        = req_payload.id_v;
      cmd.source_node = req_payload.source_node;
      cmd.port_byte   = req_payload.port_byte;
      cmd.bcast       = (req_payload.port_byte == BCAST_BYTE);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = q_ff[rd_ptr_ff];

endmodule

>>> rtl/nltf_back.sv
// back end: sequencer over node, link count and link memories
`include "assert_macros.svh"
module nltf_back #(
   parameter int MAX_NODES = 16,
   parameter int MAX_LINKS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  nltf_pkg::head_type head,
   output logic               pop,
   output logic               rsp_strobe,
   output nltf_pkg::rsp_type  rsp_payload
);
   import nltf_pkg::*;

   localparam int NW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int NCW   = $clog2(MAX_NODES + 1);
   localparam int NTW   = NCW + 1;
   localparam int LW    = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
   localparam int LCW   = $clog2(MAX_LINKS + 1);
   localparam int CW    = LCW + 2;
   localparam int LAW   = $clog2(MAX_NODES * MAX_LINKS);
   localparam int ENT_W = NW + LW;
   localparam int SRCW  = NCW + 4;
   localparam int PW    = LCW + 8;

   localparam int SW = 4;
   localparam logic [SW-1:0] S_IDLE    = 4'd0;
   localparam logic [SW-1:0] S_SCAN    = 4'd1;
   localparam logic [SW-1:0] S_CNT_U   = 4'd2;
   localparam logic [SW-1:0] S_CNT_V   = 4'd3;
   localparam logic [SW-1:0] S_CHECK   = 4'd4;
   localparam logic [SW-1:0] S_WR_U    = 4'd5;
   localparam logic [SW-1:0] S_WR_V    = 4'd6;
   localparam logic [SW-1:0] S_FWD_CNT = 4'd7;
   localparam logic [SW-1:0] S_FWD_DEC = 4'd8;
   localparam logic [SW-1:0] S_FWD_RUN = 4'd9;

   function automatic logic [LAW-1:0] link_addr(input logic [NW-1:0]  node,
                                                input logic [LCW-1:0] slot);
      link_addr = LAW'(node) * LAW'(MAX_LINKS) + LAW'(slot);
   endfunction

   // control registers
   logic [SW-1:0]  state_ff, state_in;
   logic [NCW-1:0] node_total_ff, node_total_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   logic           cmp_vld_ff, cmp_vld_in;
   logic           v1_ff, v1_in;
   logic           v2_ff, v2_in;

   // working registers
   cmd_type        cmd_ff, cmd_in;
   rsp_type        rsp_ff, rsp_in;
   logic [NCW-1:0] issue_ff, issue_in;
   logic [NW-1:0]  cmp_idx_ff, cmp_idx_in;
   logic           hu_ff, hu_in, hv_ff, hv_in;
   logic [NW-1:0]  iu_ff, iu_in, iv_ff, iv_in;
   logic [LCW-1:0] cu_ff, cu_in;
   logic [LCW-1:0] eu_ff, eu_in, ev_ff, ev_in;
   logic           new_u_ff, new_u_in, new_v_ff, new_v_in;
   logic [NCW-1:0] nt_new_ff, nt_new_in;
   logic [LCW-1:0] lj_ff, lj_in, lend_ff, lend_in;
   logic [LCW-1:0] j1_ff, j1_in, j2_ff, j2_in;
   logic [NW-1:0]  far2_ff, far2_in;
   logic [LW-1:0]  back2_ff, back2_in;

   // memory ports
   logic              node_we, lt_we, link_we;
   logic [NW-1:0]     node_waddr, node_raddr, lt_waddr, lt_raddr;
   logic [31:0]       node_wdata, node_rdata;
   logic [LCW-1:0]    lt_wdata, lt_rdata;
   logic [LAW-1:0]    link_waddr, link_raddr;
   logic [ENT_W-1:0]  link_wdata, link_rdata;
   logic [NW-1:0]     link_far;
   logic [LW-1:0]     link_back;

   // add link decision
   logic [NTW-1:0] need;
   logic           nodes_full, links_full, self_hit;
   logic [NW-1:0]  iu_new, iv_new;
   logic [NCW-1:0] nt1;
   logic           new_v;
   logic [LCW-1:0] eu_new, ev_new;

   assign link_far  = link_rdata[ENT_W-1:LW];
   assign link_back = link_rdata[LW-1:0];

   nltf_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_addr (node_raddr),
      .rd_data (node_rdata)
   );

   nltf_ram #(.WIDTH(LCW), .DEPTH(MAX_NODES)) u_count_ram (
      .clock   (clock),
      .wr_en   (lt_we),
      .wr_addr (lt_waddr),
      .wr_data (lt_wdata),
      .rd_addr (lt_raddr),
      .rd_data (lt_rdata)
   );

   nltf_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NODES * MAX_LINKS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

   // capacity checks and new indexes, valid in S_CHECK
   always_comb begin
      need = NTW'(!hu_ff) + NTW'(!hv_ff && (hu_ff || (cmd_ff.id_v != cmd_ff.id_u)));
      nodes_full = (NTW'(node_total_ff) + need) > NTW'(MAX_NODES);
      self_hit   = hu_ff && hv_ff && (iu_ff == iv_ff);
      if (self_hit) begin
         links_full = (CW'(cu_ff) + CW'(2)) > CW'(MAX_LINKS);
      end else begin
         links_full = (hu_ff && ((CW'(cu_ff) + CW'(1)) > CW'(MAX_LINKS))) ||
                      (hv_ff && ((CW'(lt_rdata) + CW'(1)) > CW'(MAX_LINKS)));
      end
      iu_new = hu_ff ? iu_ff : NW'(node_total_ff);
      nt1    = node_total_ff + NCW'(!hu_ff);
      if (hv_ff) begin
         iv_new = iv_ff;
         new_v  = 1'b0;
      end else if (cmd_ff.id_v == cmd_ff.id_u) begin
         iv_new = iu_new;
         new_v  = 1'b0;
      end else begin
         iv_new = NW'(nt1);
         new_v  = 1'b1;
      end
      eu_new = hu_ff ? cu_ff : '0;
      if (iv_new == iu_new) begin
         ev_new = eu_new + LCW'(1);
      end else begin
         ev_new = hv_ff ? lt_rdata : '0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      node_total_in = node_total_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      cmp_vld_in    = cmp_vld_ff;
      v1_in         = v1_ff;
      v2_in         = v2_ff;
      cmd_in        = cmd_ff;
      issue_in      = issue_ff;
      cmp_idx_in    = cmp_idx_ff;
      hu_in         = hu_ff;
      hv_in         = hv_ff;
      iu_in         = iu_ff;
      iv_in         = iv_ff;
      cu_in         = cu_ff;
      eu_in         = eu_ff;
      ev_in         = ev_ff;
      new_u_in      = new_u_ff;
      new_v_in      = new_v_ff;
      nt_new_in     = nt_new_ff;
      lj_in         = lj_ff;
      lend_in       = lend_ff;
      j1_in         = j1_ff;
      j2_in         = j2_ff;
      far2_in       = far2_ff;
      back2_in      = back2_ff;
      pop           = 1'b0;

      node_we    = 1'b0;
      node_waddr = iu_ff;
      node_wdata = cmd_ff.id_u;
      node_raddr = NW'(issue_ff);
      lt_we      = 1'b0;
      lt_waddr   = iu_ff;
      lt_wdata   = eu_ff + LCW'(1);
      lt_raddr   = iu_ff;
      link_we    = 1'b0;
      link_waddr = link_addr(iu_ff, eu_ff);
      link_wdata = {iv_ff, LW'(ev_ff)};
      link_raddr = link_addr(NW'(cmd_ff.source_node), lj_ff);

      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               pop        = 1'b1;
               cmd_in     = head.cmd;
               issue_in   = '0;
               cmp_vld_in = 1'b0;
               hu_in      = 1'b0;
               hv_in      = 1'b0;
               case (head.cmd.op)
                  OP_ADD, OP_FIND: begin
                     state_in = S_SCAN;
                  end
                  OP_FWD: begin
                     if (SRCW'(head.cmd.source_node) >= SRCW'(node_total_ff)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in = pack_rsp(ST_UNKNOWN, 4'd0, 32'd0, 4'd0, 1'b1);
                     end else begin
                        state_in = S_FWD_CNT;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue_ff != node_total_ff) begin
               issue_in   = issue_ff + NCW'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = NW'(issue_ff);
            end else begin
               cmp_vld_in = 1'b0;
            end
            if (cmp_vld_ff) begin
               if (!hu_ff && (node_rdata == cmd_ff.id_u)) begin
                  hu_in = 1'b1;
                  iu_in = cmp_idx_ff;
               end
               if (!hv_ff && (node_rdata == cmd_ff.id_v)) begin
                  hv_in = 1'b1;
                  iv_in = cmp_idx_ff;
               end
            end
            if ((issue_ff == node_total_ff) && !cmp_vld_ff) begin
               if (cmd_ff.op == OP_FIND) begin
                  rsp_strobe_in = 1'b1;
                  if (hu_ff) begin
                     rsp_in = pack_rsp(ST_OK, 4'(iu_ff), cmd_ff.id_u, 4'd0, 1'b1);
                  end else begin
                     rsp_in = pack_rsp(ST_UNKNOWN, 4'd0, 32'd0, 4'd0, 1'b1);
                  end
                  state_in = S_IDLE;
               end else begin
                  state_in = S_CNT_U;
               end
            end
         end
         S_CNT_U: begin
            lt_raddr = iu_ff;
            state_in = S_CNT_V;
         end
         S_CNT_V: begin
            lt_raddr = iv_ff;
            cu_in    = lt_rdata;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (nodes_full) begin
               rsp_strobe_in = 1'b1;
               rsp_in   = pack_rsp(ST_NODES_FULL, 4'd0, 32'd0, 4'd0, 1'b1);
               state_in = S_IDLE;
            end else if (links_full) begin
               rsp_strobe_in = 1'b1;
               rsp_in   = pack_rsp(ST_LINKS_FULL, 4'd0, 32'd0, 4'd0, 1'b1);
               state_in = S_IDLE;
            end else begin
               iu_in     = iu_new;
               iv_in     = iv_new;
               new_u_in  = !hu_ff;
               new_v_in  = new_v;
               eu_in     = eu_new;
               ev_in     = ev_new;
               nt_new_in = nt1 + NCW'(new_v);
               state_in  = S_WR_U;
            end
         end
         S_WR_U: begin
            node_we    = new_u_ff;
            node_waddr = iu_ff;
            node_wdata = cmd_ff.id_u;
            lt_we      = 1'b1;
            lt_waddr   = iu_ff;
            lt_wdata   = eu_ff + LCW'(1);
            link_we    = 1'b1;
            link_waddr = link_addr(iu_ff, eu_ff);
            link_wdata = {iv_ff, LW'(ev_ff)};
            state_in   = S_WR_V;
         end
         S_WR_V: begin
            node_we    = new_v_ff;
            node_waddr = iv_ff;
            node_wdata = cmd_ff.id_v;
            lt_we      = 1'b1;
            lt_waddr   = iv_ff;
            lt_wdata   = ev_ff + LCW'(1);
            link_we    = 1'b1;
            link_waddr = link_addr(iv_ff, ev_ff);
            link_wdata = {iu_ff, LW'(eu_ff)};
            node_total_in = nt_new_ff;
            rsp_strobe_in = 1'b1;
            rsp_in   = pack_rsp(ST_OK, 4'(iu_ff), cmd_ff.id_u, 4'(eu_ff), 1'b1);
            state_in = S_IDLE;
         end
         S_FWD_CNT: begin
            lt_raddr = NW'(cmd_ff.source_node);
            state_in = S_FWD_DEC;
         end
         S_FWD_DEC: begin
            v1_in = 1'b0;
            v2_in = 1'b0;
            if (cmd_ff.bcast) begin
               if (lt_rdata == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in   = pack_rsp(ST_NO_LINKS, 4'd0, 32'd0, 4'd0, 1'b1);
                  state_in = S_IDLE;
               end else begin
                  lj_in    = '0;
                  lend_in  = lt_rdata;
                  state_in = S_FWD_RUN;
               end
            end else if (PW'(cmd_ff.port_byte) >= PW'(lt_rdata)) begin
               rsp_strobe_in = 1'b1;
               rsp_in   = pack_rsp(ST_BAD_PORT, 4'd0, 32'd0, 4'd0, 1'b1);
               state_in = S_IDLE;
            end else begin
               lj_in    = LCW'(cmd_ff.port_byte);
               lend_in  = LCW'(cmd_ff.port_byte) + LCW'(1);
               state_in = S_FWD_RUN;
            end
         end
         S_FWD_RUN: begin
            // stage 0 reads the link, stage 1 reads the far id, stage 2 emits
            link_raddr = link_addr(NW'(cmd_ff.source_node), lj_ff);
            if (lj_ff != lend_ff) begin
               v1_in = 1'b1;
               j1_in = lj_ff;
               lj_in = lj_ff + LCW'(1);
            end else begin
               v1_in = 1'b0;
            end
            node_raddr = link_far;
            v2_in      = v1_ff;
            if (v1_ff) begin
               j2_in    = j1_ff;
               far2_in  = link_far;
               back2_in = link_back;
            end
            if (v2_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_in = pack_rsp(ST_OK, 4'(far2_ff), node_rdata, 4'(back2_ff),
                                 (j2_ff + LCW'(1)) == lend_ff);
            end
            if (!v1_ff && !v2_ff && (lj_ff == lend_ff)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_total_ff <= '0;
         rsp_strobe_ff <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_total_ff <= node_total_in;
         rsp_strobe_ff <= rsp_strobe_in;
         cmp_vld_ff    <= cmp_vld_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      rsp_ff     <= rsp_in;
      issue_ff   <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
      hu_ff      <= hu_in;
      hv_ff      <= hv_in;
      iu_ff      <= iu_in;
      iv_ff      <= iv_in;
      cu_ff      <= cu_in;
      eu_ff      <= eu_in;
      ev_ff      <= ev_in;
      new_u_ff   <= new_u_in;
      new_v_ff   <= new_v_in;
      nt_new_ff  <= nt_new_in;
      lj_ff      <= lj_in;
      lend_ff    <= lend_in;
      j1_ff      <= j1_in;
      j2_ff      <= j2_in;
      far2_ff    <= far2_in;
      back2_ff   <= back2_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   `NLTF_ASSERT_IMPLY(a_node_bound, clock, reset, 1'b1, node_total_ff <= NCW'(MAX_NODES), "node count beyond table size")
   `NLTF_ASSERT_IMPLY(a_err_last, clock, reset, rsp_strobe_ff && (rsp_ff.status != ST_OK), rsp_ff.last, "error result without last")
   `NLTF_ASSERT_NEXT(a_burst_gapless, clock, reset, rsp_strobe_ff && !rsp_ff.last, rsp_strobe_ff, "broadcast burst broke before last")

endmodule
